/* sv/aes_pkg.sv */
// ----------------------------------------------------------------------------
// AES package
// Shared types, register indexes, S-box and GF(2^8) helpers for the AES core.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_pkg;

   localparam int KEY_WORDS = 60;
   localparam int KEY_ADDR_W = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_ADDR_W-1:0] REG_KEY0 = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_KEY1 = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_KEY2 = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_KEY3 = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_KLEN = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_MODE = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_LOAD,
      ST_ROUND,
      ST_DONE
   } state_type;

   localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
   };

   // Inverse S-box, searched from the forward table.
   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 256; i++) begin
         if (SBOX[i] == x) begin
            r = 8'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
              a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
              a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
              xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
   endfunction

   // InvMixColumns as MixColumns after a pre-multiply by {05,00,04,00}.
   function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3, u, v;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      u = xtime(xtime(a0 ^ a2));
      v = xtime(xtime(a1 ^ a3));
      return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] x);
      return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
   endfunction

endpackage
`default_nettype wire

/* sv/aes_ram.sv */
// ----------------------------------------------------------------------------
// AES generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 60
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* sv/aes_block_cipher.sv */
// ----------------------------------------------------------------------------
// AES block cipher
// Iterative AES-128/192/256 ECB core with on-chip key expansion.
// ----------------------------------------------------------------------------
// Each block takes a key load and initial key add, then per round four column reads,
// the round op and write back, then a move into the output register, for 10, 12 or
// 14 rounds. A new request is taken only after the result has left for the output
// register; round keys come through the single column-wide read port of the key store.
// Key expansion after a key or length write copies each key word, then reads and
// writes each derived word in turn. Reset (synchronous) clears control state and configuration registers.
`default_nettype none
module aes_block_cipher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_in_hi,
   input  wire logic [63:0] req_in_lo,
   input  wire logic        req_last_block,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [63:0] rsp_out_hi,
   output logic      [63:0] rsp_out_lo,
   output logic             rsp_out_last,
   input  wire logic        csr_write,
   input  wire logic [aes_pkg::CSR_ADDR_W-1:0] csr_index,
   input  wire logic [aes_pkg::CSR_DATA_W-1:0] csr_data
);
   localparam int AW = aes_pkg::KEY_ADDR_W;

   aes_pkg::state_type state_ff, state_in;
   logic [63:0]  key_ff [4];
   logic [1:0]   klen_ff;
   logic         mode_ff, expand_req_ff, expand_req_in;
   logic [127:0] blk_ff, blk_in;
   logic         blk_last_ff;
   logic         last_ff;
   logic [127:0] rk_ff, rk_in;      // assembled round key
   logic [3:0]   round_ff, round_in;
   logic [2:0]   step_ff, step_in;  // sub-step within a round
   logic [AW-1:0] widx_ff, widx_in; // expansion word index
   logic         ephase_ff, ephase_in;
   logic [31:0]  prev_ff, prev_in;  // w[i-1] during expansion
   logic [3:0]   rcon_cnt_ff, rcon_cnt_in;
   logic [2:0]   mod_ff, mod_in;    // i mod nk
   logic [127:0] out_ff;
   logic         rsp_valid_ff;
   logic         out_load;

   logic          ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [31:0]   ram_wd, ram_rd;

   logic [1:0] lc;
   logic [3:0] nr;
   logic [2:0] nk;
   logic [AW-1:0] total;
   assign lc    = (klen_ff == 2'd3) ? 2'd2 : klen_ff;
   assign nr    = 4'd10 + {1'b0, lc, 1'b0};
   assign nk    = 3'd4 + {lc, 1'b0} - 3'd0;
   assign total = AW'(4) * (AW'(11) + AW'(lc) * AW'(2));

   aes_ram #(.WIDTH(32), .DEPTH(aes_pkg::KEY_WORDS)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         klen_ff <= 2'd0;
         mode_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            aes_pkg::REG_KEY0: key_ff[0] <= csr_data;
            aes_pkg::REG_KEY1: key_ff[1] <= csr_data;
            aes_pkg::REG_KEY2: key_ff[2] <= csr_data;
            aes_pkg::REG_KEY3: key_ff[3] <= csr_data;
            aes_pkg::REG_KLEN: klen_ff <= csr_data[1:0];
            aes_pkg::REG_MODE: mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Current round key index (enc: round, dec: nr - round).
   logic [3:0] rk_round;
   assign rk_round = mode_ff ? (nr - round_ff) : round_ff;

   // Round datapath: one full round per application of the shared unit.
   logic [7:0]   sb [16];
   logic [127:0] sr, mc, st;
   logic [31:0]  rk_fix [4];
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         sb[i] = mode_ff ? aes_pkg::inv_sbox(blk_ff[127-8*i -: 8])
                         : aes_pkg::SBOX[blk_ff[127-8*i -: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (mode_ff) begin
               sr[127-8*(4*((c+r)%4)+r) -: 8] = sb[4*c+r];
            end else begin
               sr[127-8*(4*c+r) -: 8] = sb[4*((c+r)%4)+r];
            end
         end
      end
      for (int c = 0; c < 4; c++) begin
         mc[127-32*c -: 32] = mode_ff ? aes_pkg::inv_mix_col(sr[127-32*c -: 32])
                                      : aes_pkg::mix_col(sr[127-32*c -: 32]);
         rk_fix[c] = (mode_ff && round_ff != nr) ?
                     aes_pkg::inv_mix_col(rk_ff[127-32*c -: 32]) : rk_ff[127-32*c -: 32];
      end
      st = ((round_ff == nr) ? sr : mc) ^ {rk_fix[0], rk_fix[1], rk_fix[2], rk_fix[3]};
   end

   // Expansion word computation.
   logic [31:0] t_word, w_new, seed;
   logic [7:0]  rcon;
   always_comb begin
      rcon = 8'h01;
      for (int k = 0; k < 10; k++) begin
         if (4'(k) == rcon_cnt_ff) rcon = (k == 8) ? 8'h1B : (k == 9) ? 8'h36 : 8'(1 << k);
      end
      if (mod_ff == 3'd0) begin
         t_word = aes_pkg::sub_word({prev_ff[23:0], prev_ff[31:24]}) ^ {rcon, 24'h0};
      end else if (nk == 3'd0 && mod_ff == 3'd4) begin
         t_word = aes_pkg::sub_word(prev_ff);
      end else begin
         t_word = prev_ff;
      end
      w_new = ram_rd ^ t_word;
      seed = widx_ff[0] ? key_ff[widx_ff[2:1]][31:0] : key_ff[widx_ff[2:1]][63:32];
   end

   // The finished block moves to the output register once that is free.
   assign out_load = (state_ff == aes_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      expand_req_in = expand_req_ff;
      blk_in = blk_ff; rk_in = rk_ff; round_in = round_ff; step_in = step_ff;
      widx_in = widx_ff; ephase_in = ephase_ff; prev_in = prev_ff;
      rcon_cnt_in = rcon_cnt_ff; mod_in = mod_ff;
      ram_we = 1'b0; ram_wa = widx_ff; ram_wd = w_new;
      ram_ra = widx_ff - AW'(nk == 3'd0 ? 8 : nk);
      if (csr_write && csr_index <= aes_pkg::REG_KLEN) expand_req_in = 1'b1;
      unique case (state_ff)
         aes_pkg::ST_IDLE: begin
            if (expand_req_ff) begin
               state_in = aes_pkg::ST_EXPAND;
               expand_req_in = csr_write && csr_index <= aes_pkg::REG_KLEN;
               widx_in = '0; ephase_in = 1'b0; mod_in = 3'd0; rcon_cnt_in = 4'd0;
            end else if (req_valid) begin
               state_in = aes_pkg::ST_LOAD;
               blk_in = {req_in_hi, req_in_lo};
               round_in = 4'd0; step_in = 3'd0;
            end
         end
         aes_pkg::ST_EXPAND: begin
            if (widx_ff < AW'({nk == 3'd0, nk})) begin
               ram_we = 1'b1; ram_wd = seed; prev_in = seed;
               widx_in = widx_ff + AW'(1);
               if (widx_ff == AW'(nk == 3'd0 ? 7 : nk - 3'd1)) mod_in = 3'd0;
            end else if (widx_ff >= total) begin
               state_in = aes_pkg::ST_IDLE;
            end else if (!ephase_ff) begin
               ephase_in = 1'b1;        // read w[i-nk]
            end else begin
               ram_we = 1'b1; prev_in = w_new; ephase_in = 1'b0;
               widx_in = widx_ff + AW'(1);
               if (mod_ff == 3'd0) rcon_cnt_in = rcon_cnt_ff + 4'd1;
               mod_in = (mod_ff == (nk == 3'd0 ? 3'd7 : nk - 3'd1)) ? 3'd0 : mod_ff + 3'd1;
            end
         end
         aes_pkg::ST_LOAD, aes_pkg::ST_ROUND: begin
            // Read 4 columns of the round key, one per cycle.
            ram_ra = AW'({rk_round, 2'b00}) + AW'(step_ff[1:0]);
            if (step_ff >= 3'd1 && step_ff <= 3'd4) begin
               rk_in = {rk_ff[95:0], ram_rd};
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd5) begin
               step_in = 3'd0;
               if (state_ff == aes_pkg::ST_LOAD) begin
                  blk_in = blk_ff ^ rk_ff;
                  state_in = aes_pkg::ST_ROUND;
               end else begin
                  blk_in = st;
                  if (round_ff == nr) state_in = aes_pkg::ST_DONE;
               end
               round_in = round_ff + 4'd1;
            end
         end
         aes_pkg::ST_DONE: begin
            if (out_load) state_in = aes_pkg::ST_IDLE;
         end
         default: state_in = aes_pkg::ST_IDLE;
      endcase
      // Key length 256 uses 8 words: the nk field wraps to 0 in 3 bits.
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aes_pkg::ST_IDLE;
         expand_req_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         expand_req_ff <= expand_req_in;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
      blk_ff <= blk_in; rk_ff <= rk_in; round_ff <= round_in; step_ff <= step_in;
      widx_ff <= widx_in; ephase_ff <= ephase_in; prev_ff <= prev_in;
      rcon_cnt_ff <= rcon_cnt_in; mod_ff <= mod_in;
      if (state_ff == aes_pkg::ST_IDLE && state_in == aes_pkg::ST_LOAD) begin
         blk_last_ff <= req_last_block;
      end
      if (out_load) begin
         out_ff <= blk_ff;
         last_ff <= blk_last_ff;
      end
   end

   assign req_stall = !(state_ff == aes_pkg::ST_IDLE && !expand_req_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_hi = out_ff[127:64];
   assign rsp_out_lo = out_ff[63:0];
   assign rsp_out_last = last_ff;

   // Checks.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != aes_pkg::ST_IDLE) |-> req_stall) else $error("accept while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == aes_pkg::ST_DONE) |=> rsp_valid) else $error("result lost");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(out_ff)) else $error("result changed");
endmodule
`default_nettype wire

/* tb/aes_block_cipher_checker.sv */
// ----------------------------------------------------------------------------
// AES block cipher checker
// Watches the register port and the request and response channels, keeps its own key
// schedule, predicts each cipher result and compares it with the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module aes_block_cipher_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [63:0] req_in_hi,
   input  logic [63:0] req_in_lo,
   input  logic        req_last_block,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_out_hi,
   input  logic [63:0] rsp_out_lo,
   input  logic        rsp_out_last,
   input  logic        csr_write,
   input  logic [aes_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [aes_pkg::CSR_DATA_W-1:0] csr_data,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count
);
   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
      logic        last;
   } cipher_block_type;

   logic [7:0]  fwd_sub [256];
   logic [7:0]  inv_sub [256];
   logic [63:0] key_reg [4];
   logic [1:0]  key_len;
   logic        decrypting;
   logic [31:0] sched [60];
   cipher_block_type expected_blocks [$];

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int k = 0; k < 8; k++) begin
         if (b[0]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
         b = b >> 1;
      end
      return p;
   endfunction

   // Build the S-box from the field inverse and the affine map.
   initial begin
      logic [7:0] v, b;
      for (int x = 0; x < 256; x++) begin
         v = 8'h00;
         for (int y = 1; y < 256; y++)
            if (x != 0 && gmul(8'(x), 8'(y)) == 8'h01) v = 8'(y);
         b = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^
             {v[3:0], v[7:4]} ^ 8'h63;
         fwd_sub[x] = b;
         inv_sub[b] = 8'(x);
      end
   end

   function automatic int rounds_for(input logic [1:0] len);
      return (len >= 2) ? 14 : (len == 1 ? 12 : 10);
   endfunction

   // Expand the current key into the schedule words.
   task automatic expand_schedule();
      int nk, total;
      logic [31:0] t;
      logic [7:0] rcon;
      nk = rounds_for(key_len) - 6;
      total = 4 * (rounds_for(key_len) + 1);
      for (int i = 0; i < nk; i++)
         sched[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
      rcon = 8'h01;
      for (int i = nk; i < total; i++) begin
         t = sched[i - 1];
         if (i % nk == 0) begin
            t = {t[23:0], t[31:24]};
            t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]]};
            t[31:24] ^= rcon;
            rcon = gmul(rcon, 8'h02);
         end else if (nk > 6 && i % nk == 4) begin
            t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]]};
         end
         sched[i] = sched[i - nk] ^ t;
      end
   endtask

   function automatic void add_round_key(ref logic [7:0] s [16], input int rnd);
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            s[4*c + r] ^= sched[4*rnd + c][31 - 8*r -: 8];
   endfunction

   function automatic void shift(ref logic [7:0] s [16], input bit inverse);
      logic [7:0] t [16];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            if (inverse) t[4*((c + r) % 4) + r] = s[4*c + r];
            else t[4*c + r] = s[4*((c + r) % 4) + r];
      s = t;
   endfunction

   function automatic void substitute(ref logic [7:0] s [16], input bit inverse);
      for (int i = 0; i < 16; i++) s[i] = inverse ? inv_sub[s[i]] : fwd_sub[s[i]];
   endfunction

   function automatic void mix(ref logic [7:0] s [16], input bit inverse);
      logic [7:0] a [4];
      logic [7:0] k [4];
      if (inverse) begin
         k = '{8'd14, 8'd11, 8'd13, 8'd9};
      end else begin
         k = '{8'd2, 8'd3, 8'd1, 8'd1};
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) a[r] = s[4*c + r];
         for (int r = 0; r < 4; r++)
            s[4*c + r] = gmul(a[r], k[0]) ^ gmul(a[(r+1)%4], k[1]) ^
                         gmul(a[(r+2)%4], k[2]) ^ gmul(a[(r+3)%4], k[3]);
      end
   endfunction

   // Run the full cipher on one block under the current key and mode.
   function automatic logic [127:0] cipher(input logic [127:0] blk);
      logic [7:0] s [16];
      int nr;
      logic [127:0] res;
      nr = rounds_for(key_len);
      for (int i = 0; i < 16; i++) s[i] = blk[127 - 8*i -: 8];
      if (decrypting) begin
         add_round_key(s, nr);
         for (int rnd = nr - 1; rnd >= 1; rnd--) begin
            shift(s, 1); substitute(s, 1); add_round_key(s, rnd); mix(s, 1);
         end
         shift(s, 1); substitute(s, 1); add_round_key(s, 0);
      end else begin
         add_round_key(s, 0);
         for (int rnd = 1; rnd < nr; rnd++) begin
            substitute(s, 0); shift(s, 0); mix(s, 0); add_round_key(s, rnd);
         end
         substitute(s, 0); shift(s, 0); add_round_key(s, nr);
      end
      for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
      return res;
   endfunction

   assign pending_count = expected_blocks.size();

   // Compare results first, then take register writes and new requests.
   always @(posedge clock) begin
      cipher_block_type exp_blk, new_blk;
      if (reset) begin
         for (int i = 0; i < 4; i++) key_reg[i] = '0;
         key_len = '0;
         decrypting = 1'b0;
         expected_blocks.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked_count++;
            if (expected_blocks.size() == 0) begin
               $error("result with no request outstanding: hi=%h lo=%h", rsp_out_hi,
                      rsp_out_lo);
               fail_count++;
            end else begin
               exp_blk = expected_blocks.pop_front();
               if (rsp_out_hi !== exp_blk.hi) begin
                  $error("out_hi: expected %h, got %h", exp_blk.hi, rsp_out_hi);
                  fail_count++;
               end
               if (rsp_out_lo !== exp_blk.lo) begin
                  $error("out_lo: expected %h, got %h", exp_blk.lo, rsp_out_lo);
                  fail_count++;
               end
               if (rsp_out_last !== exp_blk.last) begin
                  $error("out_last: expected %b, got %b", exp_blk.last, rsp_out_last);
                  fail_count++;
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               aes_pkg::REG_KEY0, aes_pkg::REG_KEY1,
               aes_pkg::REG_KEY2, aes_pkg::REG_KEY3: begin
                  key_reg[csr_index[1:0]] = csr_data;
                  expand_schedule();
               end
               aes_pkg::REG_KLEN: begin
                  key_len = csr_data[1:0];
                  expand_schedule();
               end
               aes_pkg::REG_MODE: decrypting = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            {new_blk.hi, new_blk.lo} = cipher({req_in_hi, req_in_lo});
            new_blk.last = req_last_block;
            expected_blocks.push_back(new_blk);
         end
      end
   end

   initial begin
      fail_count = 0;
      checked_count = 0;
   end
endmodule

/* tb/aes_block_cipher_tb.sv */
// ----------------------------------------------------------------------------
// AES block cipher testbench
// Drives blocks under a series of key lengths, keys and modes with random
// gaps and stalls on both channels; the checker predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module aes_block_cipher_tb;
   localparam logic [aes_pkg::CSR_ADDR_W-1:0] UNMAPPED_INDEX_A = 3'd6;
   localparam logic [aes_pkg::CSR_ADDR_W-1:0] UNMAPPED_INDEX_B = 3'd7;
   localparam int BLOCKS_PER_SETTING = 130;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [63:0] req_in_hi = '0;
   logic [63:0] req_in_lo = '0;
   logic req_last_block = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [63:0] rsp_out_hi;
   logic [63:0] rsp_out_lo;
   logic rsp_out_last;
   logic csr_write = 1'b0;
   logic [aes_pkg::CSR_ADDR_W-1:0] csr_index = '0;
   logic [aes_pkg::CSR_DATA_W-1:0] csr_data = '0;

   int fail_count, pending_count, checked_count;
   int send_gap_pct = 37;
   int recv_stall_pct = 60;
   bit long_hold = 1'b0;
   int blocks_sent = 0;

   always #6 clock = ~clock;

   aes_block_cipher dut (.*);

   aes_block_cipher_checker checker_i (.*);

   // Receiver stalls at random, with one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall = 1'b1;
            repeat (400) @(negedge clock);
            long_hold = 1'b0;
         end
         rsp_stall = ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                             input logic last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_in_hi = hi;
      req_in_lo = lo;
      req_last_block = last;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
      req_valid = 1'b0;
      blocks_sent++;
   endtask

   task automatic write_reg(input logic [aes_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [aes_pkg::CSR_DATA_W-1:0] val);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   // Drain the block, then load a full key setting; the block holds requests off until expansion ends.
   task automatic load_setting(input logic [1:0] len, input logic mode,
                               input logic [63:0] k0, input logic [63:0] k1,
                               input logic [63:0] k2, input logic [63:0] k3);
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      write_reg(aes_pkg::REG_KLEN, {62'd0, len});
      write_reg(aes_pkg::REG_KEY0, k0);
      write_reg(aes_pkg::REG_KEY1, k1);
      write_reg(aes_pkg::REG_KEY2, k2);
      write_reg(aes_pkg::REG_KEY3, k3);
      write_reg(aes_pkg::REG_MODE, {63'd0, mode});
      write_reg(UNMAPPED_INDEX_A, {$urandom, $urandom});
      repeat (150) @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_blocks(input int count);
      for (int i = 0; i < count; i++) begin
         // Move through the idling schedule as the run progresses.
         if (blocks_sent > 1050) begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
         end else if (blocks_sent > 525) begin
            send_gap_pct = 60;
            recv_stall_pct = 37;
         end
         case ($urandom_range(9))
            0: send_block('0, rand64(), 1'($urandom_range(1)));
            1: send_block('1, rand64(), 1'($urandom_range(1)));
            default: send_block(rand64(), rand64(), 1'($urandom_range(1)));
         endcase
      end
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Directed: standard 128-bit key, extreme blocks and flag values.
      load_setting(2'd0, 1'b0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                   64'h1011121314151617, 64'h18191a1b1c1d1e1f);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
      send_block('0, '0, 1'b1);
      send_block('1, '1, 1'b0);
      send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b1);
      // Mode change alone, with no new expansion.
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      write_reg(aes_pkg::REG_MODE, 64'd1);
      write_reg(UNMAPPED_INDEX_B, '1);
      send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0);
      send_block('0, '1, 1'b1);
      // Long hold-off on the result side while requests keep coming.
      long_hold = 1'b1;
      random_blocks(6);

      load_setting(2'd1, 1'b0, '0, '0, '0, '0);
      send_block('0, '0, 1'b0);
      send_block('1, '1, 1'b1);
      load_setting(2'd2, 1'b1, '1, '1, '1, '1);
      send_block('0, '0, 1'b0);
      send_block('1, '1, 1'b1);
      load_setting(2'd3, 1'b0, rand64(), rand64(), rand64(), rand64());
      send_block('0, '1, 1'b0);
      send_block(rand64(), rand64(), 1'b1);

      // Random part over a sweep of key settings.
      for (int ph = 0; ph < 12; ph++) begin
         load_setting(2'(ph % 4), 1'(ph / 4 % 2 ^ ph % 2), rand64(), rand64(),
                      rand64(), rand64());
         random_blocks(BLOCKS_PER_SETTING);
      end

      while (pending_count != 0) @(negedge clock);
      repeat (120) @(negedge clock);
      $display("Sent %0d blocks over 128/192/256-bit keys in both directions;",
               blocks_sent);
      $display("checked %0d results with gaps, stalls and a long hold-off.",
               checked_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule

/* filelist.f */
sv/aes_pkg.sv
sv/aes_ram.sv
sv/aes_block_cipher.sv
tb/aes_block_cipher_checker.sv
tb/aes_block_cipher_tb.sv
